FILE: rtl/rapc_pkg.sv
// rapc_pkg: shared types, widths and codes of the read-ahead page cache tag controller
// depends on: nothing
package rapc_pkg;

    // sizes
    localparam int PAGES        = 32;
    localparam int PAGE_W       = 5;
    localparam int CNT_W        = 6;
    localparam int FILE_ID_BITS = 8;
    localparam int FID_W        = 8;
    localparam int OFF_W        = 32;
    localparam int LEN_W        = 16;
    localparam int STAMP_W      = 32;
    localparam int OP_W         = 2;
    localparam int OUTC_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // outcome codes
    localparam logic [OUTC_W-1:0] OC_DIRECT   = 4'd0;
    localparam logic [OUTC_W-1:0] OC_HIT      = 4'd1;
    localparam logic [OUTC_W-1:0] OC_PARTIAL  = 4'd2;
    localparam logic [OUTC_W-1:0] OC_MISS     = 4'd3;
    localparam logic [OUTC_W-1:0] OC_FILLED   = 4'd4;
    localparam logic [OUTC_W-1:0] OC_FILL_ERR = 4'd5;
    localparam logic [OUTC_W-1:0] OC_CLEARED  = 4'd6;
    localparam logic [OUTC_W-1:0] OC_TOO_LONG = 4'd7;
    localparam logic [OUTC_W-1:0] OC_NO_PEND  = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 2'd1;

    // register reset values
    localparam logic [LEN_W-1:0] PAGE_BYTES_RST = 16'd7236;
    localparam logic [CNT_W-1:0] PAGES_RST      = 6'd32;
    localparam logic [CNT_W-1:0] PAGES_CNT      = 6'(PAGES);

    // one tag entry as stored in the tag memory
    typedef struct packed {
        logic [FILE_ID_BITS-1:0] owner;
        logic [OFF_W-1:0]        start;
        logic [STAMP_W-1:0]      last_use;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

FILE: rtl/rapc_ram.sv
// rapc_ram: generic single write port, single read port ram with registered read
// depends on: nothing
module rapc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/read_ahead_page_cache_lru_unit.sv
// read_ahead_page_cache_lru_unit: tag controller of a read-ahead page cache
// depends on: rapc_pkg, rapc_ram (tag memory)
// a read or a clear walks the tag memory once, one page per cycle, over the active pages;
// fill done, direct and too-long items skip the walk; the result register is loaded
// when the item commits, which waits while an earlier result has not been taken
// reset (synchronous, active low) frees every page through per-page valid flags at once
module read_ahead_page_cache_lru_unit
    import rapc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [FID_W-1:0]      i_file_id,
    input  logic [OFF_W-1:0]      i_offset,
    input  logic [LEN_W-1:0]      i_length,
    input  logic                  i_fill_ok,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUTC_W-1:0]     o_outcome,
    output logic [PAGE_W-1:0]     o_hit_page,
    output logic [LEN_W-1:0]      o_hit_start,
    output logic [LEN_W-1:0]      o_hit_bytes,
    output logic [PAGE_W-1:0]     o_fetch_page,
    output logic [OFF_W-1:0]      o_fetch_offset,
    output logic [LEN_W-1:0]      o_rest_bytes,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [LEN_W-1:0] r_page_bytes;
    logic [CNT_W-1:0] r_pages_in_use;

    // captured item
    logic [OP_W-1:0]         r_op;
    logic [FILE_ID_BITS-1:0] r_fid;
    logic [OFF_W-1:0]        r_off;
    logic [LEN_W-1:0]        r_len;
    logic                    r_ok;

    // page valid flags and shared state
    logic [PAGES-1:0]        r_valid;
    logic [STAMP_W-1:0]      r_use_clock;
    logic                    r_pend;
    logic [PAGE_W-1:0]       r_pend_page;
    logic [OFF_W-1:0]        r_pend_start;
    logic [FILE_ID_BITS-1:0] r_pend_owner;

    // walk counters
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_pipe_vld;
    logic [PAGE_W-1:0] r_pipe_idx;

    // search results
    logic               r_hit_found;
    logic               r_hit_full;
    logic [PAGE_W-1:0]  r_hit_idx;
    logic [OFF_W-1:0]   r_hit_start;
    logic [OFF_W:0]     r_hit_end;
    logic [PAGE_W-1:0]  r_lru_idx;
    logic [STAMP_W-1:0] r_lru_val;

    // result register
    logic              r_out_valid;
    logic [OUTC_W-1:0] r_outcome;
    logic [PAGE_W-1:0] r_hit_page;
    logic [LEN_W-1:0]  r_hit_pos;
    logic [LEN_W-1:0]  r_hit_bytes;
    logic [PAGE_W-1:0] r_fetch_page;
    logic [OFF_W-1:0]  r_fetch_offset;
    logic [LEN_W-1:0]  r_rest_bytes;

    logic             in_acc;
    logic             cfg_acc;
    logic             cfg_wipe;
    logic [CNT_W-1:0] active_cnt;
    logic             issue;
    logic             scan_done;
    logic             commit;
    logic             too_long;
    logic             no_pages;
    logic [STAMP_W-1:0] stamp_next;

    // tag memory ports
    logic              ram_we;
    logic [PAGE_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;

    // per-entry checks on the data coming out of the memory
    logic               e_valid;
    logic               e_match;
    logic [OFF_W:0]     e_end;
    logic               e_hit;
    logic               e_first;
    logic               e_full;
    logic [STAMP_W-1:0] e_eff;

    // finishing step
    logic              c_clr_vld;
    logic [PAGE_W-1:0] c_clr_idx;
    logic              c_set_vld;
    logic              c_stamp;
    logic              c_pend_new;
    logic              c_pend_done;
    logic [OUTC_W-1:0] c_outcome;
    logic [PAGE_W-1:0] c_hit_page;
    logic [LEN_W-1:0]  c_hit_pos;
    logic [LEN_W-1:0]  c_hit_bytes;
    logic [PAGE_W-1:0] c_fetch_page;
    logic [OFF_W-1:0]  c_fetch_offset;
    logic [LEN_W-1:0]  c_rest_bytes;
    logic [OFF_W-1:0]  h_pos32;
    logic [OFF_W:0]    h_used33;
    logic [LEN_W-1:0]  h_used;

    rapc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PAGES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[PAGE_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // handshakes and shared terms
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    // only a write to a defined register frees the pages
    assign cfg_wipe    = cfg_acc && ((i_cfg_index == CFG_PAGE_BYTES) ||
                                     (i_cfg_index == CFG_PAGES_IN_USE));
    assign active_cnt  = (r_pages_in_use > PAGES_CNT) ? PAGES_CNT : r_pages_in_use;
    assign issue       = ((r_state == S_SCAN) || (r_state == S_CLEAR)) && (r_rd_idx < active_cnt);
    assign scan_done   = (r_rd_idx == active_cnt) && !r_pipe_vld;
    assign commit      = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign too_long    = (r_len > r_page_bytes);
    assign no_pages    = (active_cnt == '0);
    assign stamp_next  = r_use_clock + 1'b1;

    // page window check for the entry read last cycle
    assign e_valid = r_valid[r_pipe_idx];
    assign e_match = e_valid && (ram_rdata.owner == r_fid);
    assign e_end   = {1'b0, ram_rdata.start} + {{(OFF_W + 1 - LEN_W){1'b0}}, r_page_bytes};
    assign e_hit   = e_match && (r_off >= ram_rdata.start) && ({1'b0, r_off} < e_end);
    assign e_first = e_hit && !r_hit_found;
    assign e_full  = ({1'b0, r_off} + {{(OFF_W + 1 - LEN_W){1'b0}}, r_len}) <= e_end;
    // the hit page is already restamped when the lru is chosen
    assign e_eff   = e_first ? stamp_next : (e_valid ? ram_rdata.last_use : '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (i_operation)
                        OP_READ: begin
                            if ((active_cnt == '0) || (i_length > r_page_bytes)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_FILL:  n_state = S_DONE;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN, S_CLEAR: begin
                if (scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hit arithmetic for the finishing step
    assign h_pos32  = r_off - r_hit_start;
    assign h_used33 = r_hit_end - {1'b0, r_off};
    assign h_used   = h_used33[LEN_W-1:0];

    // finishing step: result and state updates
    always_comb begin
        c_clr_vld      = 1'b0;
        c_clr_idx      = '0;
        c_set_vld      = 1'b0;
        c_stamp        = 1'b0;
        c_pend_new     = 1'b0;
        c_pend_done    = 1'b0;
        c_outcome      = OC_DIRECT;
        c_hit_page     = '0;
        c_hit_pos      = '0;
        c_hit_bytes    = '0;
        c_fetch_page   = '0;
        c_fetch_offset = '0;
        c_rest_bytes   = '0;
        ram_we         = 1'b0;
        ram_waddr      = r_hit_idx;
        ram_wdata      = '{owner: r_fid, start: r_hit_start, last_use: stamp_next};
        priority case (r_op)
            OP_READ: begin
                if (no_pages) begin
                    c_outcome = OC_DIRECT;
                end else if (too_long) begin
                    c_outcome = OC_TOO_LONG;
                end else begin
                    if (r_hit_found) begin
                        ram_we     = commit;
                        c_stamp    = 1'b1;
                        c_hit_page = r_hit_idx;
                        c_hit_pos  = h_pos32[LEN_W-1:0];
                    end
                    if (r_hit_found && r_hit_full) begin
                        c_outcome   = OC_HIT;
                        c_hit_bytes = r_len;
                    end else begin
                        c_clr_vld    = 1'b1;
                        c_clr_idx    = r_lru_idx;
                        c_pend_new   = 1'b1;
                        c_fetch_page = r_lru_idx;
                        if (r_hit_found) begin
                            c_outcome      = OC_PARTIAL;
                            c_hit_bytes    = h_used;
                            c_fetch_offset = r_hit_end[OFF_W-1:0];
                            c_rest_bytes   = r_len - h_used;
                        end else begin
                            c_outcome      = OC_MISS;
                            c_fetch_offset = r_off;
                            c_rest_bytes   = r_len;
                        end
                    end
                end
            end
            OP_FILL: begin
                if (!r_pend) begin
                    c_outcome = OC_NO_PEND;
                end else begin
                    c_pend_done    = 1'b1;
                    c_fetch_page   = r_pend_page;
                    c_fetch_offset = r_pend_start;
                    ram_waddr      = r_pend_page;
                    ram_wdata      = '{owner: r_pend_owner, start: r_pend_start,
                                       last_use: stamp_next};
                    if (r_ok) begin
                        ram_we    = commit;
                        c_stamp   = 1'b1;
                        c_set_vld = 1'b1;
                        c_outcome = OC_FILLED;
                    end else begin
                        c_clr_vld = 1'b1;
                        c_clr_idx = r_pend_page;
                        c_outcome = OC_FILL_ERR;
                    end
                end
            end
            default: begin
                c_outcome   = OC_CLEARED;
                c_pend_done = r_pend && (r_pend_owner == r_fid);
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes   <= PAGE_BYTES_RST;
            r_pages_in_use <= PAGES_RST;
        end else if (cfg_acc) begin
            if (i_cfg_index == CFG_PAGE_BYTES) begin
                r_page_bytes <= i_cfg_data[LEN_W-1:0];
            end else if (i_cfg_index == CFG_PAGES_IN_USE) begin
                r_pages_in_use <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_operation;
            r_fid <= i_file_id[FILE_ID_BITS-1:0];
            r_off <= i_offset;
            r_len <= i_length;
            r_ok  <= i_fill_ok;
        end
    end

    // page valid flags: a page that is not valid reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (cfg_wipe) begin
            r_valid <= '0;
        end else begin
            if ((r_state == S_CLEAR) && r_pipe_vld && e_match) begin
                r_valid[r_pipe_idx] <= 1'b0;
            end
            if (commit && c_clr_vld) begin
                r_valid[c_clr_idx] <= 1'b0;
            end
            if (commit && c_set_vld) begin
                r_valid[r_pend_page] <= 1'b1;
            end
        end
    end

    // use counter and pending fetch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_clock  <= '0;
            r_pend       <= 1'b0;
            r_pend_page  <= '0;
            r_pend_start <= '0;
            r_pend_owner <= '0;
        end else if (cfg_wipe) begin
            r_pend       <= 1'b0;
            r_pend_page  <= '0;
            r_pend_start <= '0;
            r_pend_owner <= '0;
        end else if (commit) begin
            if (c_stamp) begin
                r_use_clock <= stamp_next;
            end
            if (c_pend_new) begin
                r_pend       <= 1'b1;
                r_pend_page  <= c_fetch_page;
                r_pend_start <= c_fetch_offset;
                r_pend_owner <= r_fid;
            end else if (c_pend_done) begin
                r_pend <= 1'b0;
            end
        end
    end

    // memory walk: issue one address a cycle, check it the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx   <= '0;
            r_pipe_vld <= 1'b0;
            r_pipe_idx <= '0;
        end else begin
            if (in_acc) begin
                r_rd_idx <= '0;
            end else if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            r_pipe_vld <= issue;
            r_pipe_idx <= r_rd_idx[PAGE_W-1:0];
        end
    end

    // first hit and least recently used page
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found <= 1'b0;
        end else if (in_acc) begin
            r_hit_found <= 1'b0;
        end else if ((r_state == S_SCAN) && r_pipe_vld && e_first) begin
            r_hit_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && r_pipe_vld) begin
            if (e_first) begin
                r_hit_idx   <= r_pipe_idx;
                r_hit_start <= ram_rdata.start;
                r_hit_end   <= e_end;
                r_hit_full  <= e_full;
            end
            if ((r_pipe_idx == '0) || (e_eff < r_lru_val)) begin
                r_lru_idx <= r_pipe_idx;
                r_lru_val <= e_eff;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_outcome      <= c_outcome;
            r_hit_page     <= c_hit_page;
            r_hit_pos      <= c_hit_pos;
            r_hit_bytes    <= c_hit_bytes;
            r_fetch_page   <= c_fetch_page;
            r_fetch_offset <= c_fetch_offset;
            r_rest_bytes   <= c_rest_bytes;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_hit_page     = r_hit_page;
    assign o_hit_start    = r_hit_pos;
    assign o_hit_bytes    = r_hit_bytes;
    assign o_fetch_page   = r_fetch_page;
    assign o_fetch_offset = r_fetch_offset;
    assign o_rest_bytes   = r_rest_bytes;

endmodule

FILE: rtl/rapc_checker.sv
// rapc_checker: port level checks of the page cache tag controller, bound to the top level
// depends on: rapc_pkg, read_ahead_page_cache_lru_unit
module rapc_checker
    import rapc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [OP_W-1:0]       i_operation,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [OUTC_W-1:0]     o_outcome,
    input logic [PAGE_W-1:0]     o_hit_page,
    input logic [LEN_W-1:0]      o_hit_start,
    input logic [LEN_W-1:0]      o_hit_bytes,
    input logic [PAGE_W-1:0]     o_fetch_page,
    input logic [OFF_W-1:0]      o_fetch_offset,
    input logic [LEN_W-1:0]      o_rest_bytes,
    input logic                  o_cfg_ready
);

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before its transaction");

    // a real item makes the block busy in the cycle after its acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        (i_operation == OP_READ || i_operation == OP_FILL || i_operation == OP_CLEAR)
        |=> !o_in_ready)
        else $error("input still ready after accepting an item");

    // no config while an item is at work
    a_cfg_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> !o_cfg_ready)
        else $error("config ready while busy");

    // outcomes without page fields carry zeros
    a_bare_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OC_DIRECT || o_outcome == OC_TOO_LONG ||
        o_outcome == OC_NO_PEND || o_outcome == OC_CLEARED)
        |-> (o_hit_page == '0 && o_hit_start == '0 && o_hit_bytes == '0 &&
             o_fetch_page == '0 && o_fetch_offset == '0 && o_rest_bytes == '0))
        else $error("nonzero field on a bare outcome");

    // a full hit issues no fetch
    a_hit_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OC_HIT)
        |-> (o_fetch_page == '0 && o_fetch_offset == '0 && o_rest_bytes == '0))
        else $error("fetch fields set on a full hit");

endmodule

bind read_ahead_page_cache_lru_unit rapc_checker u_rapc_checker (.*);

FILE: dv/tb.sv
// tb: self-checking bench for read_ahead_page_cache_lru_unit, the page cache tag controller
// a directed table then random read/fill/clear traffic with some noise, checked against a tag predictor
// depends on: rapc_pkg, read_ahead_page_cache_lru_unit
`timescale 1ns / 100ps

module tb;
    import rapc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 48;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int PRESSURE_AFTER  = 150;
    localparam int PRESSURE_CYCLES = 600;
    localparam int DIR_COUNT       = 25;
    localparam int MAX_REPORTS     = 10;

    // codes the block must treat as no-ops
    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [FID_W-1:0] fid;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic             ok;
    } cache_req_t;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [PAGE_W-1:0] hit_page;
        logic [LEN_W-1:0]  hit_start;
        logic [LEN_W-1:0]  hit_bytes;
        logic [PAGE_W-1:0] fetch_page;
        logic [OFF_W-1:0]  fetch_offset;
        logic [LEN_W-1:0]  rest_bytes;
    } cache_res_t;

    typedef struct packed {
        cache_req_t rq;
        logic       typed;
        cache_res_t want;
    } dir_row_t;

    // block ports
    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation    = '0;
    logic [FID_W-1:0]      i_file_id      = '0;
    logic [OFF_W-1:0]      i_offset       = '0;
    logic [LEN_W-1:0]      i_length       = '0;
    logic                  i_fill_ok      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [OUTC_W-1:0]     o_outcome;
    logic [PAGE_W-1:0]     o_hit_page;
    logic [LEN_W-1:0]      o_hit_start;
    logic [LEN_W-1:0]      o_hit_bytes;
    logic [PAGE_W-1:0]     o_fetch_page;
    logic [OFF_W-1:0]      o_fetch_offset;
    logic [LEN_W-1:0]      o_rest_bytes;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // predicted tag state
    logic [OFF_W-1:0]   pg_start [PAGES];
    logic [STAMP_W-1:0] pg_stamp [PAGES];
    logic [FID_W-1:0]   pg_owner [PAGES];
    logic               pg_valid [PAGES];
    logic [STAMP_W-1:0] stamp_clock;
    logic               fetch_pending;
    logic [PAGE_W-1:0]  pend_page;
    logic [OFF_W-1:0]   pend_start;
    logic [FID_W-1:0]   pend_owner;
    logic [LEN_W-1:0]   cfg_page_bytes;
    logic [CNT_W-1:0]   cfg_pages;

    cache_res_t  outcomes_due [$];
    int          fail_count   = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;
    int unsigned sender_calm  = 0;
    logic [FID_W-1:0] file_pool [4];
    logic [OFF_W-1:0] base_pool [4];

    // settings walked by the random part; phase 0 keeps the reset values
    logic [CFG_DATA_W-1:0] phase_pb    [PHASES] =
        '{16'd7236, 16'd1, 16'hFFFF, 16'd512, 16'd300, 16'd4096, 16'd40};
    logic [CFG_DATA_W-1:0] phase_pages [PHASES] =
        '{16'd32, 16'd1, 16'd32, 16'd0, 16'hFFFF, 16'h0045, 16'd3};

    // directed stimulus at reset settings (7236 bytes, 32 pages)
    dir_row_t dir_rows [DIR_COUNT] = '{
        '{'{OP_FILL, 8'h00, 32'h0, 16'h0, 1'b1}, 1'b1,
          '{OC_NO_PEND, 5'd0, 16'd0, 16'd0, 5'd0, 32'h0, 16'd0}},
        '{'{OP_READ, 8'h00, 32'h0, 16'd7237, 1'b0}, 1'b1,
          '{OC_TOO_LONG, 5'd0, 16'd0, 16'd0, 5'd0, 32'h0, 16'd0}},
        '{'{OP_READ, 8'hA5, 32'h1000, 16'd100, 1'b1}, 1'b1,
          '{OC_MISS, 5'd0, 16'd0, 16'd0, 5'd0, 32'h1000, 16'd100}},
        '{'{OP_FILL, 8'h00, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1'b1,
          '{OC_FILLED, 5'd0, 16'd0, 16'd0, 5'd0, 32'h1000, 16'd0}},
        '{'{OP_READ, 8'hA5, 32'h100A, 16'd50, 1'b0}, 1'b1,
          '{OC_HIT, 5'd0, 16'd10, 16'd50, 5'd0, 32'h0, 16'd0}},
        '{'{OP_READ, 8'hA5, 32'h2C20, 16'd100, 1'b0}, 1'b0, '0},
        '{'{OP_FILL, 8'h00, 32'h0, 16'h0, 1'b0}, 1'b0, '0},
        '{'{OP_READ, 8'hA5, 32'hFFFF_FF00, 16'd7236, 1'b1}, 1'b0, '0},
        '{'{OP_FILL, 8'h00, 32'h0, 16'h0, 1'b1}, 1'b0, '0},
        '{'{OP_READ, 8'hA5, 32'hFFFF_FFFF, 16'd7236, 1'b0}, 1'b0, '0},
        '{'{OP_FILL, 8'h00, 32'h0, 16'h0, 1'b1}, 1'b0, '0},
        '{'{OP_READ, 8'hA5, 32'h0000_1B44, 16'd7236, 1'b0}, 1'b0, '0},
        '{'{OP_READ, 8'h5A, 32'h1000, 16'd1, 1'b0}, 1'b0, '0},
        '{'{OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{OP_FILL, 8'h00, 32'h0, 16'h0, 1'b1}, 1'b0, '0},
        '{'{OP_READ, 8'h5A, 32'h1000, 16'd0, 1'b0}, 1'b0, '0},
        '{'{OP_CLEAR, 8'hA5, 32'h1234, 16'h0055, 1'b1}, 1'b1,
          '{OC_CLEARED, 5'd0, 16'd0, 16'd0, 5'd0, 32'h0, 16'd0}},
        '{'{OP_READ, 8'hA5, 32'h100A, 16'd50, 1'b0}, 1'b0, '0},
        '{'{OP_CLEAR, 8'hA5, 32'h0, 16'h0, 1'b0}, 1'b1,
          '{OC_CLEARED, 5'd0, 16'd0, 16'd0, 5'd0, 32'h0, 16'd0}},
        '{'{OP_FILL, 8'h00, 32'h0, 16'h0, 1'b1}, 1'b1,
          '{OC_NO_PEND, 5'd0, 16'd0, 16'd0, 5'd0, 32'h0, 16'd0}},
        '{'{OP_READ, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1'b1,
          '{OC_TOO_LONG, 5'd0, 16'd0, 16'd0, 5'd0, 32'h0, 16'd0}},
        '{'{OP_READ, 8'hFF, 32'hFFFF_FFFF, 16'd0, 1'b0}, 1'b0, '0},
        '{'{OP_FILL, 8'h00, 32'h0, 16'h0, 1'b1}, 1'b0, '0},
        '{'{OP_READ, 8'hFF, 32'hFFFF_FFFF, 16'd1, 1'b0}, 1'b0, '0},
        '{'{OP_READ, 8'hFF, 32'hFFFF_FFFF, 16'd7236, 1'b0}, 1'b0, '0}
    };

    read_ahead_page_cache_lru_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_file_id      (i_file_id),
        .i_offset       (i_offset),
        .i_length       (i_length),
        .i_fill_ok      (i_fill_ok),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_outcome      (o_outcome),
        .o_hit_page     (o_hit_page),
        .o_hit_start    (o_hit_start),
        .o_hit_bytes    (o_hit_bytes),
        .o_fetch_page   (o_fetch_page),
        .o_fetch_offset (o_fetch_offset),
        .o_rest_bytes   (o_rest_bytes),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // tag state helpers
    function automatic void drop_page(input int unsigned p);
        pg_start[p] = '1;
        pg_stamp[p] = '0;
        pg_owner[p] = '0;
        pg_valid[p] = 1'b0;
    endfunction

    function automatic void wipe_cache();
        int i;
        for (i = 0; i < PAGES; i++) drop_page(i);
        fetch_pending = 1'b0;
        pend_page     = '0;
        pend_start    = '0;
        pend_owner    = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PAGE_BYTES: begin
                cfg_page_bytes = data[LEN_W-1:0];
                wipe_cache();
            end
            CFG_PAGES_IN_USE: begin
                cfg_pages = data[CNT_W-1:0];
                wipe_cache();
            end
            default: ;
        endcase
    endfunction

    // expected outcome of one transaction; updates the predicted tag state
    function automatic logic predict_outcome(input cache_req_t rq, output cache_res_t res);
        int unsigned n;
        int unsigned lru;
        int          i;
        int          hit_idx;
        logic [OFF_W:0]   s;
        logic [OFF_W:0]   e;
        logic [LEN_W-1:0] used;
        logic [LEN_W-1:0] rest;
        logic [OFF_W-1:0] next_off;
        res = '0;
        n = (cfg_pages > PAGES) ? PAGES : cfg_pages;
        case (rq.op)
            OP_READ: begin
                if (n == 0) begin
                    res.outcome = OC_DIRECT;
                    return 1'b1;
                end
                if (rq.len > cfg_page_bytes) begin
                    res.outcome = OC_TOO_LONG;
                    return 1'b1;
                end
                next_off = rq.off;
                rest     = rq.len;
                hit_idx  = -1;
                // first page of this file whose window holds the offset
                for (i = 0; i < n; i++) begin
                    s = {1'b0, pg_start[i]};
                    e = s + cfg_page_bytes;
                    if (hit_idx < 0 && pg_valid[i] && pg_owner[i] == rq.fid &&
                        {1'b0, rq.off} >= s && {1'b0, rq.off} < e) begin
                        stamp_clock   = stamp_clock + 1;
                        pg_stamp[i]   = stamp_clock;
                        res.hit_page  = 5'(i);
                        res.hit_start = 16'(rq.off - pg_start[i]);
                        if ({1'b0, rq.off} + rq.len <= e) begin
                            res.outcome   = OC_HIT;
                            res.hit_bytes = rq.len;
                            return 1'b1;
                        end
                        used          = 16'(e - {1'b0, rq.off});
                        res.hit_bytes = used;
                        rest          = rq.len - used;
                        next_off      = e[OFF_W-1:0];
                        hit_idx       = i;
                    end
                end
                // least recently used page, lowest index on ties
                lru = 0;
                for (i = 1; i < n; i++)
                    if (pg_stamp[i] < pg_stamp[lru]) lru = i;
                drop_page(lru);
                fetch_pending    = 1'b1;
                pend_page        = 5'(lru);
                pend_start       = next_off;
                pend_owner       = rq.fid;
                res.outcome      = (hit_idx >= 0) ? OC_PARTIAL : OC_MISS;
                res.fetch_page   = 5'(lru);
                res.fetch_offset = next_off;
                res.rest_bytes   = rest;
                return 1'b1;
            end
            OP_FILL: begin
                if (!fetch_pending) begin
                    res.outcome = OC_NO_PEND;
                    return 1'b1;
                end
                if (rq.ok) begin
                    stamp_clock         = stamp_clock + 1;
                    pg_start[pend_page] = pend_start;
                    pg_owner[pend_page] = pend_owner;
                    pg_valid[pend_page] = 1'b1;
                    pg_stamp[pend_page] = stamp_clock;
                    res.outcome         = OC_FILLED;
                end else begin
                    drop_page(pend_page);
                    res.outcome = OC_FILL_ERR;
                end
                res.fetch_page   = pend_page;
                res.fetch_offset = pend_start;
                fetch_pending    = 1'b0;
                return 1'b1;
            end
            OP_CLEAR: begin
                for (i = 0; i < n; i++)
                    if (pg_valid[i] && pg_owner[i] == rq.fid) drop_page(i);
                if (fetch_pending && pend_owner == rq.fid) fetch_pending = 1'b0;
                res.outcome = OC_CLEARED;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // gap length: mostly short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // random request aimed at cached pages and their borders most of the time
    function automatic cache_req_t random_request();
        cache_req_t  rq;
        int unsigned pb;
        int unsigned pick;
        int          k;
        int          j;
        int          tgt;
        pb     = cfg_page_bytes;
        rq.op  = OP_READ;
        rq.fid = file_pool[$urandom_range(0, 3)];
        rq.off = $urandom;
        rq.len = 16'($urandom);
        rq.ok  = 1'($urandom);
        pick   = $urandom_range(0, 99);
        // noise: any operation, any fields
        if (pick < 8) begin
            rq.op  = 2'($urandom);
            rq.fid = 8'($urandom);
            return rq;
        end
        if (pick < 18) begin
            rq.op = OP_FILL;
            rq.ok = ($urandom_range(0, 5) != 0);
            return rq;
        end
        if (pick < 24) begin
            rq.op = OP_CLEAR;
            return rq;
        end
        k   = $urandom_range(0, PAGES - 1);
        tgt = -1;
        for (j = 0; j < PAGES; j++)
            if (tgt < 0 && pg_valid[(k + j) % PAGES]) tgt = (k + j) % PAGES;
        if (tgt >= 0 && $urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 4) != 0) rq.fid = pg_owner[tgt];
            case ($urandom_range(0, 3))
                0:       rq.off = pg_start[tgt] + 32'(pb) - 1;
                1:       rq.off = pg_start[tgt] + 32'(pb);
                default: rq.off = pg_start[tgt] + $urandom_range(0, pb - 1);
            endcase
        end else begin
            rq.off = base_pool[$urandom_range(0, 3)] + $urandom_range(0, 2 * pb);
        end
        case ($urandom_range(0, 9))
            0:       rq.len = 16'(pb);
            1:       rq.len = (pb < 65535) ? 16'($urandom_range(pb + 1, 65535)) : 16'hFFFF;
            2:       rq.len = 16'($urandom_range(0, 3));
            default: rq.len = 16'($urandom_range(0, pb));
        endcase
        return rq;
    endfunction

    // offer one request transaction and record its expected outcome on acceptance
    task automatic offer_item(input cache_req_t rq, input logic typed, input cache_res_t want);
        int unsigned gap;
        cache_res_t  res;
        logic        has_res;
        gap = 0;
        if (sender_calm > 0) sender_calm--;
        else if ($urandom_range(0, 99) < 3) sender_calm = 30;
        else if ($urandom_range(0, 9) < 3) gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= rq.op;
        i_file_id   <= rq.fid;
        i_offset    <= rq.off;
        i_length    <= rq.len;
        i_fill_ok   <= rq.ok;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        has_res = predict_outcome(rq, res);
        if (has_res) outcomes_due.push_back(typed ? want : res);
    endtask

    // register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, data);
    endtask

    // wait until every outcome is back and the block has gone quiet
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string why, input cache_res_t want,
                                   input cache_res_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, why);
            $display("  exp outcome=%0d hit_page=%0d hit_start=%0d hit_bytes=%0d fetch_page=%0d fetch_offset=%h rest=%0d",
                     want.outcome, want.hit_page, want.hit_start, want.hit_bytes,
                     want.fetch_page, want.fetch_offset, want.rest_bytes);
            $display("  got outcome=%0d hit_page=%0d hit_start=%0d hit_bytes=%0d fetch_page=%0d fetch_offset=%h rest=%0d",
                     got.outcome, got.hit_page, got.hit_start, got.hit_bytes,
                     got.fetch_page, got.fetch_offset, got.rest_bytes);
        end
    endtask

    // result checking
    always @(posedge i_clk) begin : reply_check
        cache_res_t got;
        cache_res_t want;
        if (o_out_valid === 1'b1 && i_out_ready) begin
            got = {o_outcome, o_hit_page, o_hit_start, o_hit_bytes,
                   o_fetch_page, o_fetch_offset, o_rest_bytes};
            results_seen++;
            if (outcomes_due.size() == 0) begin
                report_mismatch("result transaction with nothing expected", '0, got);
            end else begin
                want = outcomes_due.pop_front();
                if (got.outcome !== want.outcome || got.hit_page !== want.hit_page ||
                    got.hit_start !== want.hit_start || got.hit_bytes !== want.hit_bytes ||
                    got.fetch_page !== want.fetch_page ||
                    got.fetch_offset !== want.fetch_offset ||
                    got.rest_bytes !== want.rest_bytes)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // result side pacing, with one long hold-off while requests keep coming
    initial begin : sink_pacing
        int unsigned stall_left;
        int unsigned calm_left;
        logic        pressure_done;
        stall_left    = 0;
        calm_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!pressure_done && results_seen >= PRESSURE_AFTER && i_in_valid) begin
                stall_left    = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end else if (stall_left == 0) begin
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(0, 99) < 2) calm_left = 200;
                else if ($urandom_range(0, 99) < 15) stall_left = idle_len();
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        int ph;
        int r;
        int sent;
        cache_req_t rq;
        cache_req_t fill_rq;
        stamp_clock    = '0;
        cfg_page_bytes = PAGE_BYTES_RST;
        cfg_pages      = PAGES_RST;
        wipe_cache();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (r = 0; r < DIR_COUNT; r++)
            offer_item(dir_rows[r].rq, dir_rows[r].typed, dir_rows[r].want);

        // random phases over several register settings
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                settle_block();
                if (ph == PHASES - 1) write_reg(CFG_UNUSED, 16'hA5A5);
                write_reg(CFG_PAGE_BYTES, phase_pb[ph]);
                write_reg(CFG_PAGES_IN_USE, phase_pages[ph]);
                i_cfg_valid <= 1'b0;
            end
            for (r = 0; r < 4; r++) begin
                file_pool[r] = 8'($urandom);
                base_pool[r] = $urandom;
            end
            base_pool[0] = '0;
            base_pool[1] = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(cfg_page_bytes));
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                rq = random_request();
                offer_item(rq, 1'b0, '0);
                if (rq.op != OP_UNUSED) sent++;
                // most reads are followed by their fill done
                if (rq.op == OP_READ && $urandom_range(0, 9) < 7) begin
                    fill_rq     = '0;
                    fill_rq.op  = OP_FILL;
                    fill_rq.fid = 8'($urandom);
                    fill_rq.ok  = ($urandom_range(0, 6) != 0);
                    offer_item(fill_rq, 1'b0, '0);
                    sent++;
                end
            end
        end

        // drain and finish
        settle_block();
        if (fail_count == 0 && outcomes_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rapc_pkg.sv
rtl/rapc_ram.sv
rtl/read_ahead_page_cache_lru_unit.sv
rtl/rapc_checker.sv
dv/tb.sv
